### src/alst_pkg.sv
// Shared types and constants for the bounded ordered list engine.
package alst_pkg;

	// Default number of list entries.
	localparam int DEPTH_DEF = 16;

	// Field widths of one stream word.
	localparam int MODE_W = 4;
	localparam int POS_W  = 4;
	localparam int NUM_W  = 32;
	localparam int STAT_W = 2;

	// Operation codes carried in the mode field.
	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR      = 4'd0,
		MODE_INSERT     = 4'd1,
		MODE_DELETE     = 4'd2,
		MODE_PUSH_BACK  = 4'd3,
		MODE_POP_BACK   = 4'd4,
		MODE_PUSH_FRONT = 4'd5,
		MODE_POP_FRONT  = 4'd6,
		MODE_READ       = 4'd7,
		MODE_MERGE      = 4'd8
	} mode_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_RD_ISSUE,
		S_RD_WAIT,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_UP_RD,
		S_UP_WR,
		S_DN_RD,
		S_DN_WR,
		S_FIN
	} state_t;

endpackage

### src/array_list_insert_delete_merge.sv
// Errors, clear, pop back and unused modes go straight to the result; a merge scans the
// list and then shifts entries, the longest path. Each item can also wait for the previous
// result word to be taken.
// The engine takes one word at a time; entries move by read-then-write through the single
// entry RAM.
// Reset: arst_n clears the count, the merge cursor and the handshakes; entry contents
// are left as they are and are only read below the count.
module array_list_insert_delete_merge #(
	parameter int DEPTH = alst_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// s_tdata fields from bit 0: mode[3:0], pos[7:4], number[39:8]
	input  logic [39:0]                      s_tdata,
	// s_tlast: last, marks the final element of a merged second list
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// m_tdata fields from bit 0: status, read_value, count, then zero fill
	output logic [((34+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int AW   = $clog2(DEPTH);
	localparam int CMPW = (CW > alst_pkg::POS_W) ? CW : alst_pkg::POS_W;
	localparam int OUTW = ((34 + CW + 7) / 8) * 8;
	localparam int PADW = OUTW - 34 - CW;

	alst_pkg::state_t  state_q, state_nx;
	alst_pkg::mode_t   mode_q;
	alst_pkg::status_t exec_status, res_status_q;

	logic [alst_pkg::POS_W-1:0] pos_q;
	logic [alst_pkg::NUM_W-1:0] num_q, res_rd_q, rdata, wdata;
	logic                       last_q;
	logic [CW-1:0]              count_q, cursor_q, idx_q, at_q;
	logic [CW-1:0]              idx_m1, idx_p1, cur_lim;
	logic [CMPW-1:0]            pos_x, cnt_x;
	logic                       m_tvalid_q;
	logic [OUTW-1:0]            m_tdata_q;
	logic                       we;
	logic [AW-1:0]              waddr, raddr;
	logic                       full, empty, ins_bad, acc_bad, less, fin_fire;

	// Entry storage.
	alst_ram #(
		.WIDTH (alst_pkg::NUM_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Conditions on the current word and list.
	always_comb begin
		pos_x   = CMPW'(pos_q);
		cnt_x   = CMPW'(count_q);
		full    = (count_q == CW'(DEPTH));
		empty   = (count_q == '0);
		ins_bad = (pos_x > cnt_x);
		acc_bad = (pos_x >= cnt_x);
		less    = ($signed(rdata) < $signed(num_q));
		idx_m1  = idx_q - CW'(1);
		idx_p1  = idx_q + CW'(1);
		cur_lim = (cursor_q > count_q) ? count_q : cursor_q;
	end

	// Status decided when an operation starts.
	always_comb begin
		exec_status = alst_pkg::ST_OK;
		unique case (mode_q)
			alst_pkg::MODE_INSERT: begin
				if (full) exec_status = alst_pkg::ST_FULL;
				else if (ins_bad) exec_status = alst_pkg::ST_BADPOS;
			end
			alst_pkg::MODE_DELETE, alst_pkg::MODE_READ: begin
				if (empty) exec_status = alst_pkg::ST_EMPTY;
				else if (acc_bad) exec_status = alst_pkg::ST_BADPOS;
			end
			alst_pkg::MODE_PUSH_BACK, alst_pkg::MODE_PUSH_FRONT, alst_pkg::MODE_MERGE: begin
				if (full) exec_status = alst_pkg::ST_FULL;
			end
			alst_pkg::MODE_POP_BACK, alst_pkg::MODE_POP_FRONT: begin
				if (empty) exec_status = alst_pkg::ST_EMPTY;
			end
			default: exec_status = alst_pkg::ST_OK;
		endcase
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			alst_pkg::S_IDLE: begin
				if (s_tvalid) state_nx = alst_pkg::S_EXEC;
			end
			alst_pkg::S_EXEC: begin
				if (exec_status != alst_pkg::ST_OK) begin
					state_nx = alst_pkg::S_FIN;
				end else begin
					unique case (mode_q)
						alst_pkg::MODE_INSERT, alst_pkg::MODE_PUSH_BACK,
						alst_pkg::MODE_PUSH_FRONT: state_nx = alst_pkg::S_UP_RD;
						alst_pkg::MODE_DELETE, alst_pkg::MODE_POP_FRONT:
							state_nx = alst_pkg::S_DN_RD;
						alst_pkg::MODE_READ:  state_nx = alst_pkg::S_RD_ISSUE;
						alst_pkg::MODE_MERGE: state_nx = alst_pkg::S_SCAN_RD;
						default:              state_nx = alst_pkg::S_FIN;
					endcase
				end
			end
			alst_pkg::S_RD_ISSUE: state_nx = alst_pkg::S_RD_WAIT;
			alst_pkg::S_RD_WAIT:  state_nx = alst_pkg::S_FIN;
			alst_pkg::S_SCAN_RD: begin
				state_nx = (idx_q < count_q) ? alst_pkg::S_SCAN_CMP : alst_pkg::S_UP_RD;
			end
			alst_pkg::S_SCAN_CMP: begin
				state_nx = less ? alst_pkg::S_SCAN_RD : alst_pkg::S_UP_RD;
			end
			alst_pkg::S_UP_RD: begin
				state_nx = (idx_q > at_q) ? alst_pkg::S_UP_WR : alst_pkg::S_FIN;
			end
			alst_pkg::S_UP_WR: state_nx = alst_pkg::S_UP_RD;
			alst_pkg::S_DN_RD: begin
				state_nx = (idx_p1 < count_q) ? alst_pkg::S_DN_WR : alst_pkg::S_FIN;
			end
			alst_pkg::S_DN_WR: state_nx = alst_pkg::S_DN_RD;
			alst_pkg::S_FIN: begin
				if (!m_tvalid_q || m_tready) state_nx = alst_pkg::S_IDLE;
			end
			default: state_nx = alst_pkg::S_IDLE;
		endcase
	end

	// Handshake and RAM controls for each state.
	always_comb begin
		s_tready = 1'b0;
		fin_fire = 1'b0;
		we       = 1'b0;
		waddr    = idx_q[AW-1:0];
		wdata    = rdata;
		raddr    = idx_q[AW-1:0];
		unique case (state_q)
			alst_pkg::S_IDLE: s_tready = 1'b1;
			alst_pkg::S_UP_RD: begin
				raddr = idx_m1[AW-1:0];
				if (idx_q <= at_q) begin
					we    = 1'b1;
					waddr = at_q[AW-1:0];
					wdata = num_q;
				end
			end
			alst_pkg::S_UP_WR, alst_pkg::S_DN_WR: we = 1'b1;
			alst_pkg::S_DN_RD: raddr = idx_p1[AW-1:0];
			alst_pkg::S_FIN:   fin_fire = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	// Control state: sequencer, count, merge cursor, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= alst_pkg::S_IDLE;
			count_q    <= '0;
			cursor_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == alst_pkg::S_EXEC) begin
				if (mode_q <= alst_pkg::MODE_READ) cursor_q <= '0;
				if (mode_q == alst_pkg::MODE_MERGE && full && last_q) cursor_q <= '0;
				if (mode_q == alst_pkg::MODE_CLEAR) count_q <= '0;
				if (mode_q == alst_pkg::MODE_POP_BACK && !empty) count_q <= count_q - CW'(1);
			end
			if (state_q == alst_pkg::S_UP_RD && idx_q <= at_q) begin
				count_q <= count_q + CW'(1);
				if (mode_q == alst_pkg::MODE_MERGE) begin
					cursor_q <= last_q ? '0 : at_q + CW'(1);
				end
			end
			if (state_q == alst_pkg::S_DN_RD && idx_p1 >= count_q) begin
				count_q <= count_q - CW'(1);
			end
			if (fin_fire) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// Word, cursor positions and result payload.
	always_ff @(posedge clk) begin
		unique case (state_q)
			alst_pkg::S_IDLE: begin
				if (s_tvalid) begin
					mode_q <= alst_pkg::mode_t'(s_tdata[3:0]);
					pos_q  <= s_tdata[7:4];
					num_q  <= s_tdata[39:8];
					last_q <= s_tlast;
				end
			end
			alst_pkg::S_EXEC: begin
				res_status_q <= exec_status;
				res_rd_q     <= '0;
				unique case (mode_q)
					alst_pkg::MODE_INSERT: begin
						idx_q <= count_q;
						at_q  <= CW'(pos_q);
					end
					alst_pkg::MODE_PUSH_BACK: begin
						idx_q <= count_q;
						at_q  <= count_q;
					end
					alst_pkg::MODE_PUSH_FRONT: begin
						idx_q <= count_q;
						at_q  <= '0;
					end
					alst_pkg::MODE_DELETE, alst_pkg::MODE_READ: idx_q <= CW'(pos_q);
					alst_pkg::MODE_POP_FRONT: idx_q <= '0;
					alst_pkg::MODE_MERGE:     idx_q <= cur_lim;
					default: ;
				endcase
			end
			alst_pkg::S_RD_WAIT: res_rd_q <= rdata;
			alst_pkg::S_SCAN_RD: begin
				if (idx_q >= count_q) begin
					at_q  <= idx_q;
					idx_q <= count_q;
				end
			end
			alst_pkg::S_SCAN_CMP: begin
				if (less) begin
					idx_q <= idx_p1;
				end else begin
					at_q  <= idx_q;
					idx_q <= count_q;
				end
			end
			alst_pkg::S_UP_WR: idx_q <= idx_m1;
			alst_pkg::S_DN_WR: idx_q <= idx_p1;
			alst_pkg::S_FIN: begin
				if (fin_fire) begin
					m_tdata_q <= {{PADW{1'b0}}, count_q, res_rd_q, res_status_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### src/alst_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module alst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/alst_checker.sv
// Port-level checks for the ordered list engine, bound to its top level.
module alst_checker #(
	parameter int DEPTH = alst_pkg::DEPTH_DEF
) (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    s_tvalid,
	input logic                                    s_tready,
	input logic                                    m_tvalid,
	input logic                                    m_tready,
	input logic [((34+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [1:0]    st;
	logic [31:0]   rv;
	logic [CW-1:0] cnt;

	assign st  = m_tdata[1:0];
	assign rv  = m_tdata[33:2];
	assign cnt = m_tdata[33+CW:34];

	// A stalled result word holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// The engine works on one word at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an operation is in progress");

	// The count never exceeds the list depth.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt <= CW'(DEPTH))
		else $error("count beyond depth");

	// A full status is only reported on a full list.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == alst_pkg::ST_FULL |-> cnt == CW'(DEPTH))
		else $error("full status on a list that is not full");

	// A failed operation returns a zero read value.
	a_rdzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st != alst_pkg::ST_OK |-> rv == '0)
		else $error("read value set on a failed operation");

endmodule

bind array_list_insert_delete_merge alst_checker #(.DEPTH(DEPTH)) u_alst_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### tb/testbench.sv
// Self-checking testbench for the bounded ordered list engine with streamed sorted merge.
`timescale 1ns / 1ps

import alst_pkg::*;

// One result word, split into its fields.
typedef struct packed {
	status_t     status;
	logic [31:0] read_value;
	logic [4:0]  count;
} list_result_t;

// Shadow copy of the list: predicts each result word and checks the words that come back.
class list_tracker;
	logic [31:0]  shadow [DEPTH_DEF];
	int           fill;
	int           cursor;
	list_result_t expected_q [$];
	int           errors;
	int           words_in;
	int           words_out;
	int           merge_steps;
	int           status_seen [4];

	function new();
		fill = 0;
		cursor = 0;
		errors = 0;
		words_in = 0;
		words_out = 0;
		merge_steps = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
	endfunction

	// Open a slot at position at and write v there.
	function void place_at(int at, logic [31:0] v);
		for (int k = fill; k > at; k--) shadow[k] = shadow[k-1];
		shadow[at] = v;
		fill++;
	endfunction

	// Close the gap left by the entry at position at.
	function void remove_at(int at);
		for (int k = at; k + 1 < fill; k++) shadow[k] = shadow[k+1];
		fill--;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	// Apply one accepted input word to the shadow list and queue its result.
	function void note_op(logic [3:0] mode, logic [3:0] pos, logic [31:0] num, logic last);
		list_result_t r;
		int c;
		r.status = ST_OK;
		r.read_value = '0;
		words_in++;
		// Every regular operation restarts any merge in progress.
		if (mode <= MODE_READ) cursor = 0;
		case (mode)
			MODE_CLEAR: fill = 0;
			MODE_INSERT: begin
				if (fill >= DEPTH_DEF) r.status = ST_FULL;
				else if (pos > fill) r.status = ST_BADPOS;
				else place_at(pos, num);
			end
			MODE_DELETE: begin
				if (fill == 0) r.status = ST_EMPTY;
				else if (pos >= fill) r.status = ST_BADPOS;
				else remove_at(pos);
			end
			MODE_PUSH_BACK: begin
				if (fill >= DEPTH_DEF) r.status = ST_FULL;
				else place_at(fill, num);
			end
			MODE_POP_BACK: begin
				if (fill == 0) r.status = ST_EMPTY;
				else remove_at(fill - 1);
			end
			MODE_PUSH_FRONT: begin
				if (fill >= DEPTH_DEF) r.status = ST_FULL;
				else place_at(0, num);
			end
			MODE_POP_FRONT: begin
				if (fill == 0) r.status = ST_EMPTY;
				else remove_at(0);
			end
			MODE_READ: begin
				if (fill == 0) r.status = ST_EMPTY;
				else if (pos >= fill) r.status = ST_BADPOS;
				else r.read_value = shadow[pos];
			end
			MODE_MERGE: begin
				merge_steps++;
				if (fill >= DEPTH_DEF) begin
					r.status = ST_FULL;
				end else begin
					// Skip originals that are strictly smaller, then slot the element in.
					c = (cursor > fill) ? fill : cursor;
					while (c < fill && $signed(shadow[c]) < $signed(num)) c++;
					place_at(c, num);
					cursor = c + 1;
				end
				if (last) cursor = 0;
			end
			default: ;
		endcase
		r.count = fill[4:0];
		status_seen[r.status]++;
		expected_q.push_back(r);
	endfunction

	// Compare one result word with the oldest prediction, field by field.
	function void check_word(logic [39:0] word);
		list_result_t want;
		logic [1:0]  got_status;
		logic [31:0] got_value;
		logic [4:0]  got_count;
		got_status = word[1:0];
		got_value = word[33:2];
		got_count = word[38:34];
		words_out++;
		if (expected_q.size() == 0) begin
			$error("unexpected result word: status %0d, read_value %0d, count %0d",
				got_status, $signed(got_value), got_count);
			errors++;
			return;
		end
		want = expected_q.pop_front();
		if (got_status !== want.status) begin
			$error("status mismatch: expected %0d, got %0d", want.status, got_status);
			errors++;
		end
		if (got_value !== want.read_value) begin
			$error("read_value mismatch: expected %0d, got %0d",
				$signed(want.read_value), $signed(got_value));
			errors++;
		end
		if (got_count !== want.count) begin
			$error("count mismatch: expected %0d, got %0d", want.count, got_count);
			errors++;
		end
	endfunction
endclass

module testbench;

	localparam int OUT_W = ((34 + $clog2(DEPTH_DEF + 1) + 7) / 8) * 8;
	localparam logic [3:0] MODE_SPARE_LO = 4'd9;
	localparam logic [3:0] MODE_SPARE_HI = 4'd15;
	localparam int RANDOM_ITEMS = 700;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 100;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [39:0]       s_tdata = '0;
	logic              s_tlast = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	list_tracker sb = new();
	bit quiet = 1'b0;
	logic hold_rx = 1'b0;

	array_list_insert_delete_merge #(.DEPTH(DEPTH_DEF)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// 4 ns clock.
	initial begin
		forever #2 clk = ~clk;
	end

	// Gap length: mostly none or short, now and then long; none at all in quiet phases.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet) return 0;
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Number with extra weight on the extremes and on values near zero.
	function automatic logic [31:0] rand_num();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return 32'h8000_0000;
		if (r < 16) return 32'h7FFF_FFFF;
		if (r < 30) return $urandom_range(0, 8) - 4;
		return $urandom;
	endfunction

	// Offer one word and wait until the block takes it.
	task automatic send_op(input logic [3:0] mode, input logic [3:0] pos,
			input logic [31:0] num, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {num, pos, mode};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_op(mode, pos, num, last);
	endtask

	// One operation of any kind, positions mostly in range.
	task automatic send_mixed();
		int r;
		logic [3:0] mode;
		logic [3:0] pos;
		r = $urandom_range(0, 99);
		if (r < 3) mode = MODE_CLEAR;
		else if (r < 13) mode = MODE_INSERT;
		else if (r < 23) mode = MODE_DELETE;
		else if (r < 35) mode = MODE_PUSH_BACK;
		else if (r < 45) mode = MODE_POP_BACK;
		else if (r < 55) mode = MODE_PUSH_FRONT;
		else if (r < 63) mode = MODE_POP_FRONT;
		else if (r < 78) mode = MODE_READ;
		else if (r < 95) mode = MODE_MERGE;
		else mode = 4'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
		if ($urandom_range(0, 3) == 0) pos = 4'($urandom_range(0, 15));
		else pos = 4'($urandom_range(0, (sb.fill > 15) ? 15 : sb.fill));
		send_op(mode, pos, rand_num(), $urandom_range(0, 3) == 0);
	endtask

	// Result side: check accepted words, stall at random, hold off for long when asked.
	initial begin
		int stall_left;
		int hold_left;
		bit hold_done;
		stall_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_word(m_tdata[39:0]);
			if (hold_rx && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// Watchdog: too many cycles with no word moving on either side ends the run.
	initial begin
		int idle;
		idle = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
			else idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
				$display("array_list_insert_delete_merge regression: fail");
				$finish;
			end
		end
	end

	// Stimulus.
	initial begin
		int scen;
		int k;
		int n;
		int v;
		bit held_once;
		bit paused_once;
		held_once = 1'b0;
		paused_once = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, bad positions, extremes, spare modes, merge basics.
		send_op(MODE_POP_BACK, 4'd0, 32'd0, 1'b0);
		send_op(MODE_POP_FRONT, 4'd0, 32'd0, 1'b0);
		send_op(MODE_DELETE, 4'd0, 32'd0, 1'b0);
		send_op(MODE_READ, 4'd0, 32'd0, 1'b0);
		send_op(MODE_INSERT, 4'd1, 32'd7, 1'b0);
		send_op(MODE_INSERT, 4'd0, 32'h8000_0000, 1'b0);
		send_op(MODE_PUSH_BACK, 4'd0, 32'h7FFF_FFFF, 1'b0);
		send_op(MODE_PUSH_FRONT, 4'd0, 32'hFFFF_FFFF, 1'b0);
		send_op(MODE_INSERT, 4'd3, 32'd5, 1'b0);
		send_op(MODE_READ, 4'd3, 32'd0, 1'b0);
		send_op(MODE_READ, 4'd4, 32'd0, 1'b0);
		send_op(MODE_READ, 4'd15, 32'd0, 1'b0);
		send_op(MODE_DELETE, 4'd4, 32'd0, 1'b0);
		send_op(MODE_DELETE, 4'd1, 32'd0, 1'b0);
		send_op(MODE_SPARE_LO, 4'd0, 32'd0, 1'b0);
		send_op(MODE_SPARE_HI, 4'd15, 32'hFFFF_FFFF, 1'b1);
		send_op(MODE_MERGE, 4'd0, -32'sd5, 1'b0);
		send_op(MODE_MERGE, 4'd0, 32'd0, 1'b0);
		// A read in the middle restarts the merge from the front.
		send_op(MODE_READ, 4'd0, 32'd0, 1'b0);
		send_op(MODE_MERGE, 4'd0, 32'd6, 1'b1);
		send_op(MODE_MERGE, 4'd0, 32'h8000_0000, 1'b1);
		send_op(MODE_CLEAR, 4'd0, 32'd0, 1'b0);
		send_op(MODE_READ, 4'd0, 32'd0, 1'b0);
		send_op(MODE_MERGE, 4'd0, 32'd3, 1'b1);

		// Random part, built from short scenarios.
		while (sb.words_in < RANDOM_ITEMS + 24) begin
			// Receiver holds off while the sender keeps offering back to back.
			if (!held_once && sb.words_in >= 200) begin
				held_once = 1'b1;
				hold_rx <= 1'b1;
				quiet = 1'b1;
				repeat (12) send_mixed();
			end
			// Sender waits for every outstanding result once, with nothing on offer.
			if (!paused_once && sb.words_in >= 420) begin
				paused_once = 1'b1;
				s_tvalid <= 1'b0;
				do @(posedge clk); while (sb.pending() != 0);
			end
			quiet = (sb.words_in >= 500 && sb.words_in < 560);
			scen = $urandom_range(0, 99);
			if (scen < 35) begin
				// Sorted merge stream, half the time over a freshly built sorted set of originals.
				if ($urandom_range(0, 1) == 0) begin
					send_op(MODE_CLEAR, 4'($urandom_range(0, 15)), rand_num(),
						1'($urandom_range(0, 1)));
					k = $urandom_range(0, 8);
					v = -$urandom_range(0, 1 << 30);
					for (int i = 0; i < k; i++) begin
						send_op(MODE_PUSH_BACK, 4'($urandom_range(0, 15)), v,
							1'($urandom_range(0, 1)));
						v += ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1 << 26);
					end
				end
				n = $urandom_range(1, 8);
				v = -$urandom_range(0, 1 << 30);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 19) == 0) send_mixed();
					send_op(MODE_MERGE, 4'($urandom_range(0, 15)), v,
						(i == n - 1) && ($urandom_range(0, 9) != 0));
					v += ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1 << 26);
				end
			end else if (scen < 48) begin
				// Fill to the top, then hit the full list from every side.
				while (sb.fill < DEPTH_DEF) begin
					case ($urandom_range(0, 3))
						0: send_op(MODE_PUSH_BACK, 4'($urandom_range(0, 15)), rand_num(), 1'b0);
						1: send_op(MODE_PUSH_FRONT, 4'($urandom_range(0, 15)), rand_num(), 1'b0);
						2: send_op(MODE_INSERT, 4'($urandom_range(0, sb.fill)), rand_num(),
							1'($urandom_range(0, 1)));
						default: send_op(MODE_MERGE, 4'($urandom_range(0, 15)), rand_num(),
							1'($urandom_range(0, 1)));
					endcase
				end
				send_op(MODE_INSERT, 4'($urandom_range(0, 15)), rand_num(), 1'b0);
				send_op(MODE_PUSH_BACK, 4'd0, rand_num(), 1'b0);
				send_op(MODE_PUSH_FRONT, 4'd0, rand_num(), 1'b0);
				send_op(MODE_MERGE, 4'd0, rand_num(), 1'($urandom_range(0, 1)));
				send_op(MODE_READ, 4'($urandom_range(0, 15)), 32'd0, 1'b0);
			end else if (scen < 58) begin
				// Drain to empty, then try to take from the empty list.
				while (sb.fill > 0) begin
					case ($urandom_range(0, 2))
						0: send_op(MODE_POP_BACK, 4'($urandom_range(0, 15)), rand_num(), 1'b0);
						1: send_op(MODE_POP_FRONT, 4'($urandom_range(0, 15)), rand_num(), 1'b0);
						default: send_op(MODE_DELETE, 4'($urandom_range(0, sb.fill - 1)),
							rand_num(), 1'b0);
					endcase
				end
				repeat (2) begin
					case ($urandom_range(0, 3))
						0: send_op(MODE_POP_BACK, 4'($urandom_range(0, 15)), rand_num(), 1'b0);
						1: send_op(MODE_POP_FRONT, 4'($urandom_range(0, 15)), rand_num(), 1'b0);
						2: send_op(MODE_DELETE, 4'($urandom_range(0, 15)), rand_num(), 1'b0);
						default: send_op(MODE_READ, 4'($urandom_range(0, 15)), rand_num(),
							1'b0);
					endcase
				end
			end else begin
				repeat (6) send_mixed();
			end
		end
		quiet = 1'b0;
		s_tvalid <= 1'b0;

		// Let every result come back, then watch for stray words.
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d operations (%0d merge steps) and %0d result words.",
			sb.words_in, sb.merge_steps, sb.words_out);
		$display("Status mix: ok %0d, full %0d, empty %0d, bad position %0d.",
			sb.status_seen[ST_OK], sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY],
			sb.status_seen[ST_BADPOS]);
		if (sb.errors == 0) begin
			$display("array_list_insert_delete_merge regression: pass");
		end else begin
			$display("array_list_insert_delete_merge regression: fail");
		end
		$finish;
	end

endmodule

### filelist.f
src/alst_pkg.sv
src/alst_ram.sv
src/array_list_insert_delete_merge.sv
src/alst_checker.sv
tb/testbench.sv
